// File: design/filename_to_padded_8_3_macros.svh
// assertion helpers used by the datapath file
`ifndef FILENAME_TO_PADDED_8_3_MACROS_SVH
`define FILENAME_TO_PADDED_8_3_MACROS_SVH

// same-cycle implication, inactive while reset is asserted
`define FT83_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, inactive while reset is asserted
`define FT83_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ft83_pkg.sv
package ft83_pkg;

  localparam int CH_W       = 8;
  localparam int BASE_CHARS = 8;
  localparam int EXT_CHARS  = 3;
  localparam int NAME_LEN   = BASE_CHARS + EXT_CHARS;
  localparam int BCNT_W     = $clog2(BASE_CHARS + 1);
  localparam int ECNT_W     = $clog2(EXT_CHARS + 1);
  localparam int IDX_W      = $clog2(NAME_LEN);
  localparam int STAT_W     = 2;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_QUERY = 8'h3F;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOW_Z = 8'h7A;
  localparam logic [CH_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_EMPTY       = 2'd1,
    STAT_LEADING_DOT = 2'd2
  } name_stat_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;    // store a non-terminating character
    logic finish;  // terminator accepted, latch the status
    logic load;    // move the indexed byte into the output register
    logic clear;   // last byte loaded, back to the empty name
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ch_end;    // current input byte is the terminator
    logic out_free;  // output register can take a byte this cycle
    logic idx_last;  // emit index sits on the final byte
  } dp_stat_t;

  function automatic logic [CH_W-1:0] to_upper(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    r = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) r = c - CASE_OFS;
    return r;
  endfunction

endpackage

// File: design/ft83_ctrl.sv
module ft83_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ft83_pkg::dp_stat_t stat,
  output ft83_pkg::dp_cmd_t  cmd
);
  import ft83_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_COLLECT;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: if (in_tvalid && stat.ch_end) state_nxt = ST_EMIT;
      ST_EMIT:    if (stat.out_free && stat.idx_last) state_nxt = ST_COLLECT;
      default:    state_nxt = ST_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_COLLECT: begin
        in_tready  = 1'b1;
        cmd.take   = in_tvalid && !stat.ch_end;
        cmd.finish = in_tvalid && stat.ch_end;
      end
      ST_EMIT: begin
        cmd.load  = stat.out_free;
        cmd.clear = stat.out_free && stat.idx_last;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: design/ft83_dp.sv
`include "filename_to_padded_8_3_macros.svh"

module ft83_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ft83_pkg::CH_W-1:0]     ch,
  input  ft83_pkg::dp_cmd_t             cmd,
  output ft83_pkg::dp_stat_t            stat,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ft83_pkg::CH_W-1:0]     out_tdata,
  output logic [ft83_pkg::STAT_W-1:0]   out_tuser,
  output logic                          out_tlast
);
  import ft83_pkg::*;

  logic [CH_W-1:0]   store_r [NAME_LEN];
  logic [CH_W-1:0]   store_nxt [NAME_LEN];
  logic [BCNT_W-1:0] base_count_r, base_count_nxt;
  logic              base_star_r, base_star_nxt;
  logic              in_ext_r, in_ext_nxt;
  logic [ECNT_W-1:0] ext_count_r, ext_count_nxt;
  logic              ext_closed_r, ext_closed_nxt;
  logic              seen_any_r, seen_any_nxt;
  logic              lead_dot_r, lead_dot_nxt;
  name_stat_t        status_r, status_nxt;
  logic [IDX_W-1:0]  emit_idx_r, emit_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]   out_byte_r, out_byte_nxt;
  name_stat_t        out_stat_r, out_stat_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CH_W-1:0]   ch_up;

  assign ch_up         = to_upper(ch);
  assign stat.ch_end   = (ch == CH_NUL);
  assign stat.out_free = !out_valid_r || out_tready;
  assign stat.idx_last = (emit_idx_r == IDX_W'(NAME_LEN - 1));

  // name building
  always_comb begin
    store_nxt      = store_r;
    base_count_nxt = base_count_r;
    base_star_nxt  = base_star_r;
    in_ext_nxt     = in_ext_r;
    ext_count_nxt  = ext_count_r;
    ext_closed_nxt = ext_closed_r;
    seen_any_nxt   = seen_any_r;
    lead_dot_nxt   = lead_dot_r;
    if (cmd.take) begin
      seen_any_nxt = 1'b1;
      if (!in_ext_r) begin
        if (ch == CH_DOT) begin
          if (!seen_any_r) lead_dot_nxt = 1'b1;
          in_ext_nxt = 1'b1;
        end else if (!base_star_r && base_count_r < BCNT_W'(BASE_CHARS)) begin
          if (ch == CH_STAR) begin
            // star fills the remaining base positions
            for (int i = 0; i < BASE_CHARS; i++) begin
              if (BCNT_W'(i) >= base_count_r) store_nxt[i] = CH_QUERY;
            end
            base_star_nxt = 1'b1;
          end else begin
            store_nxt[IDX_W'(base_count_r)] = ch_up;
            base_count_nxt = base_count_r + 1'b1;
          end
        end
      end else if (!ext_closed_r) begin
        if (ch == CH_DOT || ch == CH_STAR) begin
          if (ch == CH_STAR) begin
            for (int i = 0; i < EXT_CHARS; i++) begin
              if (ECNT_W'(i) >= ext_count_r) store_nxt[BASE_CHARS + i] = CH_QUERY;
            end
          end
          ext_closed_nxt = 1'b1;
        end else begin
          // ext_count is below EXT_CHARS whenever the extension is open
          store_nxt[IDX_W'(BASE_CHARS) + IDX_W'(ext_count_r)] = ch_up;
          ext_count_nxt = ext_count_r + 1'b1;
          if (ext_count_r + 1'b1 >= ECNT_W'(EXT_CHARS)) ext_closed_nxt = 1'b1;
        end
      end
    end
    if (cmd.clear) begin
      for (int i = 0; i < NAME_LEN; i++) store_nxt[i] = CH_SPACE;
      base_count_nxt = '0;
      base_star_nxt  = 1'b0;
      in_ext_nxt     = 1'b0;
      ext_count_nxt  = '0;
      ext_closed_nxt = 1'b0;
      seen_any_nxt   = 1'b0;
      lead_dot_nxt   = 1'b0;
    end
  end

  // emit side
  always_comb begin
    status_nxt    = status_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    if (cmd.finish) begin
      if (!seen_any_r)     status_nxt = STAT_EMPTY;
      else if (lead_dot_r) status_nxt = STAT_LEADING_DOT;
      else                 status_nxt = STAT_OK;
    end
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = (status_r != STAT_OK) ? CH_SPACE : store_r[emit_idx_r];
      out_stat_nxt  = status_r;
      out_last_nxt  = stat.idx_last;
      emit_idx_nxt  = stat.idx_last ? '0 : emit_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAME_LEN; i++) store_r[i] <= CH_SPACE;
      base_count_r <= '0;
      base_star_r  <= 1'b0;
      in_ext_r     <= 1'b0;
      ext_count_r  <= '0;
      ext_closed_r <= 1'b0;
      seen_any_r   <= 1'b0;
      lead_dot_r   <= 1'b0;
      emit_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      store_r      <= store_nxt;
      base_count_r <= base_count_nxt;
      base_star_r  <= base_star_nxt;
      in_ext_r     <= in_ext_nxt;
      ext_count_r  <= ext_count_nxt;
      ext_closed_r <= ext_closed_nxt;
      seen_any_r   <= seen_any_nxt;
      lead_dot_r   <= lead_dot_nxt;
      emit_idx_r   <= emit_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    out_byte_r <= out_byte_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  `FT83_ASSERT_NOW(a_base_bound, clk, rst_n, 1'b1, base_count_r <= BCNT_W'(BASE_CHARS), "base count overran the base field")
  `FT83_ASSERT_NEXT(a_last_marks_end, clk, rst_n, cmd.load && stat.idx_last, out_tlast && emit_idx_r == '0, "final byte not flagged or index not rewound")
  `FT83_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear, !seen_any_r && !in_ext_r && base_count_r == '0, "name state not cleared after emit")
  `FT83_ASSERT_NOW(a_error_blank, clk, rst_n, out_valid_r && out_stat_r != STAT_OK, out_byte_r == CH_SPACE, "error name carries a non-space byte")
  `FT83_ASSERT_NOW(a_no_take_emit, clk, rst_n, cmd.load, !cmd.take && !cmd.finish, "input taken while the name is being emitted")

endmodule

// File: design/filename_to_padded_8_3.sv
// channel   | dir | tdata                  | tuser      | tlast
// ----------+-----+------------------------+------------+---------------------
// in_       | in  | [7:0] ch               | -          | -
// out_      | out | [7:0] name_byte        | [1:0] status | last (eleventh byte)
//
// a non-zero character is taken in one cycle and updates the name registers
// a zero byte ends the name: input then stalls while the 11 padded bytes leave
// one per cycle from the output register whenever out_tready does not hold it back
// the next name may start while the final byte still waits in the output register
// back-pressure on out_tready holds the emit counter and the output register
// reset (rst_n low, synchronous) clears the name to all spaces and the counters
module filename_to_padded_8_3 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ft83_pkg::CH_W-1:0]     in_tdata,   // [7:0] ch
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ft83_pkg::CH_W-1:0]     out_tdata,  // [7:0] name_byte
  output logic [ft83_pkg::STAT_W-1:0]   out_tuser,  // [1:0] status
  output logic                          out_tlast
);
  import ft83_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: collect characters, then step through the stored name
  ft83_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // name registers, field counters, status latch and output register
  ft83_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ch         (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
